FILE: hw/rtl/mbce_pkg.sv
// Package for the monochrome bitmap color expansion block.
// Holds field widths, register indexes and defaults; depends on nothing.
package mbce_pkg;

  // Dimension limit for width and height after saturation.
  localparam int unsigned MaxDim = 4096;

  // Field widths.
  localparam int unsigned AddrW   = 26;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned DimW    = 13;
  localparam int unsigned AlignW  = 3;
  localparam int unsigned RowBytW = 11;
  localparam int unsigned StrideW = 14;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegFgColor     = 3'd0,
    RegBgColor     = 3'd1,
    RegTransparent = 3'd2,
    RegBitmapWidth = 3'd3,
    RegBitmapHeight = 3'd4,
    RegBitAlign    = 3'd5,
    RegSrcRowBytes = 3'd6,
    RegDstRowBytes = 3'd7
  } cfg_reg_e;

  // Input actions.
  typedef enum logic {
    ActStart = 1'b0,
    ActByte  = 1'b1
  } action_e;

  // Register reset values.
  localparam logic [ColorW-1:0]  FgColorRst     = 16'hFFFF;
  localparam logic [ColorW-1:0]  BgColorRst     = 16'h0000;
  localparam logic [RowBytW-1:0] SrcRowBytesRst = 11'd1;

endpackage

FILE: hw/rtl/mbce_if.sv
// Valid/ready channel interfaces for the color expansion block.
// Uses widths from mbce_pkg.
interface mbce_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [7:0]                     src_byte;
  logic [mbce_pkg::CoordW-1:0]    dest_x;
  logic [mbce_pkg::CoordW-1:0]    dest_y;

  modport source (output valid, action, src_byte, dest_x, dest_y, input ready);
  modport sink   (input valid, action, src_byte, dest_x, dest_y, output ready);
endinterface

interface mbce_out_if;
  logic                           valid;
  logic                           ready;
  logic [mbce_pkg::AddrW-1:0]     dst_addr;
  logic [mbce_pkg::ColorW-1:0]    pixel_color;
  logic                           write_enable;
  logic                           last_of_item;
  logic                           last_of_blit;

  modport source (output valid, dst_addr, pixel_color, write_enable, last_of_item,
                  last_of_blit, input ready);
  modport sink   (input valid, dst_addr, pixel_color, write_enable, last_of_item,
                  last_of_blit, output ready);
endinterface

FILE: hw/rtl/mono_bitmap_color_expand_core.sv
// Top level of the monochrome bitmap color expansion block.
// Depends on mbce_pkg and the channel interfaces in mbce_if.sv.
//
//   channel   direction  carries
//   in_i      sink       action, src_byte, dest_x, dest_y
//   out_o     source     dst_addr, pixel_color, write_enable, last_of_item, last_of_blit
//   cfg       write      cfg_we_i, cfg_index_i, cfg_wdata_i
//
// A start transaction gives no result. A source byte gives one result per pixel it
// covers (up to eight), from the pixel engine that emits one result per cycle while
// the output is not stalled; a byte covering no pixel gives no result. The next byte
// is taken in the cycle the engine emits the last pixel of the current one. Reset is
// asynchronous, active low, and leaves the block idle with register defaults.
// A stalled output holds its result; the engine waits behind it.
module mono_bitmap_color_expand_core #(
  parameter int unsigned MAX_DIM = mbce_pkg::MaxDim
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbce_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mbce_pkg::CfgDatW-1:0]  cfg_wdata_i,
  mbce_in_if.sink                       in_i,
  mbce_out_if.source                    out_o
);

  localparam int unsigned AW = mbce_pkg::AddrW;
  localparam int unsigned DW = mbce_pkg::DimW;
  localparam int unsigned RW = mbce_pkg::RowBytW;

  // Configuration registers.
  logic [mbce_pkg::ColorW-1:0]  fg_color_q, bg_color_q;
  logic                         transparent_q;
  logic [DW-1:0]                bitmap_width_q, bitmap_height_q;
  logic [mbce_pkg::AlignW-1:0]  bit_align_q;
  logic [RW-1:0]                src_row_bytes_q;
  logic [mbce_pkg::StrideW-1:0] dst_row_bytes_q;

  // Blit walk state.
  logic [DW-1:0] pixel_column_q, pixel_column_d;
  logic [DW-1:0] row_index_q, row_index_d;
  logic [RW-1:0] byte_in_row_q, byte_in_row_d;
  logic [AW-1:0] row_start_addr_q, row_start_addr_d;
  logic          blit_active_q, blit_active_d;

  // Pixel engine state.
  logic          eng_busy_q, eng_busy_d;
  logic [7:0]    eng_byte_q, eng_byte_d;
  logic [3:0]    eng_cnt_q, eng_cnt_d;
  logic [AW-1:0] eng_addr_q, eng_addr_d;
  logic          eng_final_q, eng_final_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  logic [AW-1:0]               out_addr_q, out_addr_d;
  logic [mbce_pkg::ColorW-1:0] out_color_q, out_color_d;
  logic                        out_we_q, out_we_d;
  logic                        out_last_item_q, out_last_item_d;
  logic                        out_last_blit_q, out_last_blit_d;

  // Derived values.
  logic [DW-1:0]              width, height;
  logic [RW-1:0]              row_len;
  logic [mbce_pkg::AlignW-1:0] start_bit;
  logic [3:0]                 avail, npix;
  logic [DW-1:0]              rem_cols, col_sum;
  logic [RW:0]                byte_next;
  logic [DW:0]                row_next;
  logic                       last_row, final_hit, row_wrap, rows_done;
  logic                       step, in_fire;
  logic                       pix_set, pix_we;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_color_q      <= mbce_pkg::FgColorRst;
      bg_color_q      <= mbce_pkg::BgColorRst;
      transparent_q   <= 1'b0;
      bitmap_width_q  <= '0;
      bitmap_height_q <= '0;
      bit_align_q     <= '0;
      src_row_bytes_q <= mbce_pkg::SrcRowBytesRst;
      dst_row_bytes_q <= '0;
    end else if (cfg_we_i) begin
      unique case (mbce_pkg::cfg_reg_e'(cfg_index_i))
        mbce_pkg::RegFgColor:      fg_color_q      <= cfg_wdata_i;
        mbce_pkg::RegBgColor:      bg_color_q      <= cfg_wdata_i;
        mbce_pkg::RegTransparent:  transparent_q   <= cfg_wdata_i[0];
        mbce_pkg::RegBitmapWidth:  bitmap_width_q  <= cfg_wdata_i[DW-1:0];
        mbce_pkg::RegBitmapHeight: bitmap_height_q <= cfg_wdata_i[DW-1:0];
        mbce_pkg::RegBitAlign:     bit_align_q     <= cfg_wdata_i[mbce_pkg::AlignW-1:0];
        mbce_pkg::RegSrcRowBytes:  src_row_bytes_q <= cfg_wdata_i[RW-1:0];
        mbce_pkg::RegDstRowBytes:  dst_row_bytes_q <= cfg_wdata_i[mbce_pkg::StrideW-1:0];
        default: ;
      endcase
    end
  end

  // Saturated dimensions and effective row length.
  always_comb begin
    width   = (32'(bitmap_width_q) > MAX_DIM) ? DW'(MAX_DIM) : bitmap_width_q;
    height  = (32'(bitmap_height_q) > MAX_DIM) ? DW'(MAX_DIM) : bitmap_height_q;
    row_len = (src_row_bytes_q == '0) ? RW'(1) : src_row_bytes_q;
  end

  // Pixel count of the incoming byte and the walk position after it.
  always_comb begin
    start_bit = (byte_in_row_q == '0) ? bit_align_q : '0;
    avail     = 4'd8 - 4'(start_bit);
    rem_cols  = width - pixel_column_q;
    if (pixel_column_q >= width) begin
      npix = 4'd0;
    end else if (rem_cols < DW'(avail)) begin
      npix = rem_cols[3:0];
    end else begin
      npix = avail;
    end
    col_sum   = pixel_column_q + DW'(npix);
    row_next  = {1'b0, row_index_q} + (DW+1)'(1);
    last_row  = (row_next == {1'b0, height});
    rows_done = (row_next >= {1'b0, height});
    final_hit = last_row && (col_sum == width) && (npix != 4'd0);
    byte_next = {1'b0, byte_in_row_q} + (RW+1)'(1);
    row_wrap  = (byte_next >= {1'b0, row_len});
  end

  // Handshakes: the engine advances when the output register is free or drains.
  assign step        = eng_busy_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !eng_busy_q || (step && (eng_cnt_q == 4'd1));
  assign in_fire     = in_i.valid && in_i.ready;

  // Walk state and engine load on an accepted transaction.
  always_comb begin
    pixel_column_d   = pixel_column_q;
    row_index_d      = row_index_q;
    byte_in_row_d    = byte_in_row_q;
    row_start_addr_d = row_start_addr_q;
    blit_active_d    = blit_active_q;
    eng_busy_d       = eng_busy_q;
    eng_byte_d       = eng_byte_q;
    eng_cnt_d        = eng_cnt_q;
    eng_addr_d       = eng_addr_q;
    eng_final_d      = eng_final_q;

    // Engine steps through the loaded pixels.
    if (step) begin
      eng_byte_d = {eng_byte_q[6:0], 1'b0};
      eng_cnt_d  = eng_cnt_q - 4'd1;
      eng_addr_d = eng_addr_q + AW'(2);
      if (eng_cnt_q == 4'd1) begin
        eng_busy_d = 1'b0;
      end
    end

    if (in_fire) begin
      if (mbce_pkg::action_e'(in_i.action) == mbce_pkg::ActStart) begin
        row_start_addr_d = AW'(AW'(in_i.dest_y) * AW'(dst_row_bytes_q))
                         + AW'({in_i.dest_x, 1'b0});
        pixel_column_d   = '0;
        row_index_d      = '0;
        byte_in_row_d    = '0;
        blit_active_d    = (width != '0) && (height != '0);
      end else if (blit_active_q) begin
        // Load the engine when the byte covers any pixel.
        if (npix != 4'd0) begin
          eng_busy_d  = 1'b1;
          eng_byte_d  = in_i.src_byte << start_bit;
          eng_cnt_d   = npix;
          eng_addr_d  = row_start_addr_q + AW'({pixel_column_q, 1'b0});
          eng_final_d = final_hit;
        end
        pixel_column_d = col_sum;
        if (final_hit) begin
          blit_active_d = 1'b0;
        end else if (row_wrap) begin
          byte_in_row_d    = '0;
          pixel_column_d   = '0;
          row_index_d      = row_next[DW-1:0];
          row_start_addr_d = row_start_addr_q + AW'(dst_row_bytes_q);
          if (rows_done) begin
            blit_active_d = 1'b0;
          end
        end else begin
          byte_in_row_d = byte_next[RW-1:0];
        end
      end
    end
  end

  // Result formation into the output register.
  always_comb begin
    pix_set         = eng_byte_q[7];
    pix_we          = pix_set || !transparent_q;
    out_valid_d     = out_valid_q;
    out_addr_d      = out_addr_q;
    out_color_d     = out_color_q;
    out_we_d        = out_we_q;
    out_last_item_d = out_last_item_q;
    out_last_blit_d = out_last_blit_q;
    if (step) begin
      out_valid_d     = 1'b1;
      out_addr_d      = eng_addr_q;
      out_color_d     = !pix_we ? '0 : (pix_set ? fg_color_q : bg_color_q);
      out_we_d        = pix_we;
      out_last_item_d = (eng_cnt_q == 4'd1);
      out_last_blit_d = (eng_cnt_q == 4'd1) && eng_final_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_column_q   <= '0;
      row_index_q      <= '0;
      byte_in_row_q    <= '0;
      row_start_addr_q <= '0;
      blit_active_q    <= 1'b0;
      eng_busy_q       <= 1'b0;
      eng_cnt_q        <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      pixel_column_q   <= pixel_column_d;
      row_index_q      <= row_index_d;
      byte_in_row_q    <= byte_in_row_d;
      row_start_addr_q <= row_start_addr_d;
      blit_active_q    <= blit_active_d;
      eng_busy_q       <= eng_busy_d;
      eng_cnt_q        <= eng_cnt_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    eng_byte_q      <= eng_byte_d;
    eng_addr_q      <= eng_addr_d;
    eng_final_q     <= eng_final_d;
    out_addr_q      <= out_addr_d;
    out_color_q     <= out_color_d;
    out_we_q        <= out_we_d;
    out_last_item_q <= out_last_item_d;
    out_last_blit_q <= out_last_blit_d;
  end

  // Output channel.
  assign out_o.valid        = out_valid_q;
  assign out_o.dst_addr     = out_addr_q;
  assign out_o.pixel_color  = out_color_q;
  assign out_o.write_enable = out_we_q;
  assign out_o.last_of_item = out_last_item_q;
  assign out_o.last_of_blit = out_last_blit_q;

endmodule
